// ===== src/pcfr_pkg.sv =====
// pcfr_pkg: widths, constants and unit control types for the period to frequency block
// used by pcfr_divider, pcfr_multiplier and period_count_frequency_and_roc
package pcfr_pkg;

   localparam int COUNT_W   = 16;
   localparam int FREQ_W    = 30;
   localparam int ROC_W     = 45;
   localparam int SUM_W     = FREQ_W + 1;
   localparam int STEP_W    = 6;

   localparam int DIV_REM_W = 47;
   localparam int DIV_DVD_W = 44;

   localparam int MUL_A_W   = 2 * FREQ_W;
   localparam int MUL_B_W   = FREQ_W;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

   // 16000 * 65536
   localparam logic [FREQ_W-1:0] FREQ_NUMERATOR = 30'd1048576000;

   localparam logic [STEP_W-1:0] FREQ_DIV_STEPS = 6'd30;
   localparam logic [STEP_W-1:0] ROC_DIV_STEPS  = 6'd44;
   localparam logic [STEP_W-1:0] MUL_STEPS      = 6'd30;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } unit_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// ===== src/pcfr_divider.sv =====
// pcfr_divider: restoring divider, one quotient bit per cycle
// depends on pcfr_pkg for widths and the unit control types
module pcfr_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pcfr_pkg::unit_ctrl_type              ctrl,
   input  logic [pcfr_pkg::DIV_REM_W-1:0]       rem_init,
   input  logic [pcfr_pkg::DIV_DVD_W-1:0]       dvd_init,
   input  logic [pcfr_pkg::DIV_REM_W-1:0]       divisor,
   output pcfr_pkg::unit_stat_type              stat,
   output logic [pcfr_pkg::DIV_DVD_W-1:0]       quotient
);

   logic [pcfr_pkg::DIV_REM_W-1:0] rem_ff, rem_in;
   logic [pcfr_pkg::DIV_DVD_W-1:0] dvd_ff, dvd_in;
   logic [pcfr_pkg::DIV_REM_W-1:0] dsr_ff;
   logic [pcfr_pkg::STEP_W-1:0]    cnt_ff, steps_ff;
   logic                           busy_ff, done_ff;

   logic [pcfr_pkg::DIV_REM_W:0]   shifted, trial;
   logic                           ge;

   always_comb begin
      shifted = {rem_ff, dvd_ff[pcfr_pkg::DIV_DVD_W-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      trial   = shifted - {1'b0, dsr_ff};
      rem_in  = ge ? trial[pcfr_pkg::DIV_REM_W-1:0] : shifted[pcfr_pkg::DIV_REM_W-1:0];
      dvd_in  = {dvd_ff[pcfr_pkg::DIV_DVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == steps_ff - 1'b1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rem_ff   <= rem_init;
         dvd_ff   <= dvd_init;
         dsr_ff   <= divisor;
         steps_ff <= ctrl.steps;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dvd_ff;

endmodule

// ===== src/pcfr_multiplier.sv =====
// pcfr_multiplier: shift-add multiplier, one multiplier bit per cycle
// depends on pcfr_pkg for widths and the unit control types
module pcfr_multiplier (
   input  logic                               clock,
   input  logic                               reset,
   input  pcfr_pkg::unit_ctrl_type            ctrl,
   input  logic [pcfr_pkg::MUL_A_W-1:0]       multiplicand,
   input  logic [pcfr_pkg::MUL_B_W-1:0]       multiplier,
   output pcfr_pkg::unit_stat_type            stat,
   output logic [pcfr_pkg::MUL_P_W-1:0]       product
);

   logic [pcfr_pkg::MUL_P_W-1:0] prod_ff, prod_in;
   logic [pcfr_pkg::MUL_A_W-1:0] mcand_ff;
   logic [pcfr_pkg::STEP_W-1:0]  cnt_ff, steps_ff;
   logic                         busy_ff, done_ff;
   logic [pcfr_pkg::MUL_A_W:0]   acc;

   always_comb begin
      acc = {1'b0, prod_ff[pcfr_pkg::MUL_P_W-1:pcfr_pkg::MUL_B_W]}
          + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      prod_in = {acc, prod_ff[pcfr_pkg::MUL_B_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == steps_ff - 1'b1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         prod_ff  <= {{pcfr_pkg::MUL_A_W{1'b0}}, multiplier};
         mcand_ff <= multiplicand;
         steps_ff <= ctrl.steps;
      end else if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = prod_ff;

endmodule

// ===== src/period_count_frequency_and_roc.sv =====
// Period count to frequency and rate of change. Each transfer on req_ carries a period
// measured in 16 kHz ticks; one transfer on rsp_ returns the frequency in unsigned Q14.16,
// the rate of change against the previous frequency in signed Q28.16, and an error flag
// for a zero count (frequency 0, rate 0). One item is worked at a time: a nonzero count
// passes through the shared bit-serial divider (30 steps for the frequency, 44 for the
// rate) and the bit-serial multiplier (two passes of 30 steps); a zero count goes
// straight to the done state. A new item is taken while a finished result waits on rsp_stall.
// depends on pcfr_pkg, pcfr_divider and pcfr_multiplier
module period_count_frequency_and_roc (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pcfr_pkg::COUNT_W-1:0]        req_sample_count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pcfr_pkg::FREQ_W-1:0]         rsp_frequency_q16,
   output logic signed [pcfr_pkg::ROC_W-1:0]   rsp_rate_of_change_q16,
   output logic                                rsp_count_error
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FDIV = 3'd1;
   localparam logic [2:0] S_MUL1 = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_RDIV = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [pcfr_pkg::FREQ_W-1:0]   prev_ff;
   logic [pcfr_pkg::FREQ_W-1:0]   freq_ff;
   logic                          err_ff;
   logic                          neg_ff;
   logic [pcfr_pkg::ROC_W-1:0]    roc_ff;

   logic                          rsp_valid_ff;
   logic [pcfr_pkg::FREQ_W-1:0]   rsp_freq_ff;
   logic [pcfr_pkg::ROC_W-1:0]    rsp_roc_ff;
   logic                          rsp_err_ff;

   pcfr_pkg::unit_ctrl_type         div_ctrl, mul_ctrl;
   pcfr_pkg::unit_stat_type         div_stat, mul_stat;
   logic [pcfr_pkg::DIV_REM_W-1:0]  div_rem_init, div_divisor;
   logic [pcfr_pkg::DIV_DVD_W-1:0]  div_dvd_init, div_q;
   logic [pcfr_pkg::MUL_A_W-1:0]    mul_a;
   logic [pcfr_pkg::MUL_B_W-1:0]    mul_b;
   logic [pcfr_pkg::MUL_P_W-1:0]    mul_p;

   logic                            accept, out_free;
   logic [pcfr_pkg::FREQ_W-1:0]     f_new, diff;
   logic                            neg_new;
   logic [pcfr_pkg::SUM_W-1:0]      sum;
   logic [pcfr_pkg::ROC_W-1:0]      mag;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      f_new   = div_q[pcfr_pkg::FREQ_W-1:0];
      neg_new = f_new < prev_ff;
      diff    = neg_new ? prev_ff - f_new : f_new - prev_ff;
      sum     = {1'b0, freq_ff} + {1'b0, prev_ff};
      mag     = {1'b0, div_q};
   end

   // unit sequencing
   always_comb begin
      state_in     = state_ff;
      div_ctrl     = '{start: 1'b0, steps: pcfr_pkg::FREQ_DIV_STEPS};
      mul_ctrl     = '{start: 1'b0, steps: pcfr_pkg::MUL_STEPS};
      div_rem_init = '0;
      div_dvd_init = {pcfr_pkg::FREQ_NUMERATOR,
                      {(pcfr_pkg::DIV_DVD_W - pcfr_pkg::FREQ_W){1'b0}}};
      div_divisor  = {{(pcfr_pkg::DIV_REM_W - pcfr_pkg::COUNT_W){1'b0}}, req_sample_count};
      mul_a        = {{(pcfr_pkg::MUL_A_W - pcfr_pkg::FREQ_W){1'b0}}, diff};
      mul_b        = f_new;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_sample_count == '0) begin
                  state_in = S_DONE;
               end else begin
                  div_ctrl.start = 1'b1;
                  state_in       = S_FDIV;
               end
            end
         end
         S_FDIV: begin
            if (div_stat.done) begin
               mul_ctrl.start = 1'b1;
               state_in       = S_MUL1;
            end
         end
         S_MUL1: begin
            mul_a = mul_p[pcfr_pkg::MUL_A_W-1:0];
            mul_b = prev_ff;
            if (mul_stat.done) begin
               mul_ctrl.start = 1'b1;
               state_in       = S_MUL2;
            end
         end
         S_MUL2: begin
            // dividend is twice the product; its top bits start the remainder
            div_rem_init = mul_p[pcfr_pkg::MUL_P_W-1:pcfr_pkg::DIV_DVD_W-1];
            div_dvd_init = {mul_p[pcfr_pkg::DIV_DVD_W-2:0], 1'b0};
            div_divisor  = {sum, {(pcfr_pkg::DIV_REM_W - pcfr_pkg::SUM_W){1'b0}}};
            div_ctrl.steps = pcfr_pkg::ROC_DIV_STEPS;
            if (mul_stat.done) begin
               div_ctrl.start = 1'b1;
               state_in       = S_RDIV;
            end
         end
         S_RDIV: begin
            if (div_stat.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && out_free) begin
            prev_ff      <= freq_ff;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         freq_ff <= '0;
         roc_ff  <= '0;
         err_ff  <= req_sample_count == '0;
      end
      if (state_ff == S_FDIV && div_stat.done) begin
         freq_ff <= f_new;
         neg_ff  <= neg_new;
      end
      if (state_ff == S_RDIV && div_stat.done) begin
         roc_ff <= neg_ff ? (~mag) + 1'b1 : mag;
      end
      if (state_ff == S_DONE && out_free) begin
         rsp_freq_ff <= freq_ff;
         rsp_roc_ff  <= roc_ff;
         rsp_err_ff  <= err_ff;
      end
   end

   pcfr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .rem_init (div_rem_init),
      .dvd_init (div_dvd_init),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_q)
   );

   pcfr_multiplier u_multiplier (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (mul_ctrl),
      .multiplicand (mul_a),
      .multiplier   (mul_b),
      .stat         (mul_stat),
      .product      (mul_p)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_frequency_q16      = rsp_freq_ff;
   assign rsp_rate_of_change_q16 = rsp_roc_ff;
   assign rsp_count_error        = rsp_err_ff;

endmodule
